// ----- src/lkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the LRU key-value cache
// Item layouts, opcodes and derived widths for the cache datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int DATA_W  = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic                     opcode;
        logic signed [DATA_W-1:0] lookup_key;
        logic signed [DATA_W-1:0] write_value;
    } in_item_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
    } out_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
    } entry_t;

endpackage

`default_nettype wire

// ----- src/lru_key_value_cache_unit.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit: fully associative key-value cache, LRU replacement
// An accepted access steps through the states scan (one sequential read of
//   the entry memory per slot), drain (the compare of the last slot) and
//   commit, which writes back the entry on a put and updates the recency ranks.
// The next item is taken only back in idle, once the commit of the last one
//   is through. A get holds in commit while an earlier result still waits,
//   stalled, in the output register.
// Reset clears valid marks, ranks, count and handshakes; capacity returns to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire lkvc_pkg::in_item_t  in_item,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output lkvc_pkg::out_item_t    out_item,
    input  wire logic              cfg_write_en,
    input  wire logic [lkvc_pkg::CAP_W-1:0] cfg_write_data
);
    import lkvc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } state_t;

    typedef logic [RANK_W-1:0] rank_t;

    // Key and value of every slot live in one synchronous memory; valid marks
    // and recency ranks sit in flops next to it, one cell per slot.
    entry_t key_value_mem [ENTRIES];
    entry_t mem_rdata_reg;

    state_t             state_reg;
    logic [CAP_W-1:0]   capacity_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    rank_t [ENTRIES-1:0] rank_reg;
    rank_t [ENTRIES-1:0] rank_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    // Item held for the whole access.
    logic               op_reg;
    logic [DATA_W-1:0]  key_reg;
    logic [DATA_W-1:0]  wval_reg;

    // Scan pointer and the compare stage that trails it by one register.
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               cmp_en_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;

    // What the scan has found so far.
    logic               match_found_reg;
    logic [IDX_W-1:0]   match_idx_reg;
    logic [DATA_W-1:0]  match_val_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic               victim_found_reg;
    logic [IDX_W-1:0]   victim_idx_reg;
    rank_t              victim_rank_reg;

    logic               out_valid_reg;
    out_item_t          out_item_reg;

    // Commit-cycle decisions.
    logic               commit_go;
    logic               out_load;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic               do_promote;
    logic [IDX_W-1:0]   promote_idx;
    logic               do_fill;
    rank_t              old_rank;
    logic [CMP_W-1:0]   eff_cap;
    logic [CMP_W-1:0]   count_wide;
    logic               cmp_valid;
    logic               cmp_key_eq;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Clamp capacity: zero behaves as one, anything above the slot count as
    // the slot count.
    always_comb
    begin
        eff_cap = CMP_W'(capacity_reg);
        if (capacity_reg == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        if (eff_cap > CMP_W'(ENTRIES))
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
        count_wide = CMP_W'(count_reg);
    end

    assign cmp_valid  = valid_reg[cmp_idx_reg];
    assign cmp_key_eq = (mem_rdata_reg.key == key_reg);

    // A get may only finish when the output register is free or draining.
    assign commit_go = (state_reg == S_COMMIT) &&
                       ((op_reg == OP_PUT) || !out_valid_reg || !out_stall);
    assign out_load  = commit_go && (op_reg == OP_GET);

    // Decide the write-back and the rank update of the commit cycle.
    always_comb
    begin
        mem_we      = 1'b0;
        mem_waddr   = match_idx_reg;
        do_promote  = 1'b0;
        promote_idx = match_idx_reg;
        do_fill     = 1'b0;
        if (commit_go)
        begin
            if (op_reg == OP_GET)
            begin
                do_promote = match_found_reg;
            end
            else if (match_found_reg)
            begin
                mem_we     = 1'b1;
                do_promote = 1'b1;
            end
            else if ((count_wide < eff_cap) && free_found_reg)
            begin
                mem_we    = 1'b1;
                mem_waddr = free_idx_reg;
                do_fill   = 1'b1;
            end
            else
            begin
                // Evict the least recent slot and reuse it.
                mem_we      = victim_found_reg;
                mem_waddr   = victim_idx_reg;
                do_promote  = victim_found_reg;
                promote_idx = victim_idx_reg;
            end
        end
    end

    // Age every more recent slot by one and make the touched slot most recent;
    // a fill ages every valid slot.
    always_comb
    begin
        old_rank   = rank_reg[promote_idx];
        rank_next  = rank_reg;
        valid_next = valid_reg;
        count_next = count_reg;
        for (int j = 0; j < ENTRIES; j++)
        begin
            if (do_promote && valid_reg[j] && (IDX_W'(j) != promote_idx) &&
                (rank_reg[j] < old_rank))
            begin
                rank_next[j] = rank_reg[j] + rank_t'(1);
            end
            if (do_fill && valid_reg[j])
            begin
                rank_next[j] = rank_reg[j] + rank_t'(1);
            end
        end
        if (do_promote)
        begin
            rank_next[promote_idx] = '0;
        end
        if (do_fill)
        begin
            rank_next[free_idx_reg]  = '0;
            valid_next[free_idx_reg] = 1'b1;
            count_next               = count_reg + CNT_W'(1);
        end
    end

    // Entry memory: one read and one write port, read data registered.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SCAN)
        begin
            mem_rdata_reg <= key_value_mem[rd_idx_reg];
        end
        if (mem_we)
        begin
            key_value_mem[mem_waddr] <= '{key: key_reg, value: wval_reg};
        end
    end

    // Output payload holds until the item is taken.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_item_reg.hit        <= match_found_reg;
            out_item_reg.read_value <= match_found_reg ? match_val_reg : '1;
        end
    end

    // Item and scan results: payload, no reset needed.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && in_valid)
        begin
            op_reg   <= in_item.opcode;
            key_reg  <= in_item.lookup_key;
            wval_reg <= in_item.write_value;
        end
        if (cmp_en_reg)
        begin
            if (cmp_valid && cmp_key_eq && !match_found_reg)
            begin
                match_idx_reg <= cmp_idx_reg;
                match_val_reg <= mem_rdata_reg.value;
            end
            if (!cmp_valid && !free_found_reg)
            begin
                free_idx_reg <= cmp_idx_reg;
            end
            if (cmp_valid && (!victim_found_reg ||
                              (rank_reg[cmp_idx_reg] >= victim_rank_reg)))
            begin
                victim_idx_reg  <= cmp_idx_reg;
                victim_rank_reg <= rank_reg[cmp_idx_reg];
            end
        end
    end

    // Control state, cache bookkeeping and output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            capacity_reg     <= CAP_RESET;
            valid_reg        <= '0;
            rank_reg         <= '0;
            count_reg        <= '0;
            rd_idx_reg       <= '0;
            cmp_en_reg       <= 1'b0;
            cmp_idx_reg      <= '0;
            match_found_reg  <= 1'b0;
            free_found_reg   <= 1'b0;
            victim_found_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                capacity_reg <= cfg_write_data;
            end

            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            count_reg <= count_next;

            cmp_en_reg  <= (state_reg == S_SCAN);
            cmp_idx_reg <= rd_idx_reg;

            if (cmp_en_reg)
            begin
                if (cmp_valid && cmp_key_eq)
                begin
                    match_found_reg <= 1'b1;
                end
                if (!cmp_valid)
                begin
                    free_found_reg <= 1'b1;
                end
                if (cmp_valid)
                begin
                    victim_found_reg <= 1'b1;
                end
            end

            // Hold a stalled result; load a new one as the old one leaves.
            out_valid_reg <= out_load || (out_valid_reg && out_stall);

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        rd_idx_reg       <= '0;
                        match_found_reg  <= 1'b0;
                        free_found_reg   <= 1'b0;
                        victim_found_reg <= 1'b0;
                        state_reg        <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // Advance one slot a cycle; stop after the last one.
                    rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                    if (rd_idx_reg == IDX_W'(ENTRIES - 1))
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_COMMIT;
                end
                S_COMMIT:
                begin
                    if (commit_go)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // The fill count always matches the number of valid slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("occupied count out of step with valid marks");

    // The count never shrinks: evictions reuse a slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= $past(count_reg))
        else $error("occupied count decreased");

    // Every write-back leaves a valid slot behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> valid_reg[$past(mem_waddr)])
        else $error("entry written into a slot left invalid");

    // A hit found by the scan always names a valid slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT && match_found_reg) |-> valid_reg[match_idx_reg])
        else $error("hit on an invalid slot");

    // A result is loaded only on the commit of a get.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg)) |-> ($past(state_reg) == S_COMMIT && $past(op_reg) == OP_GET))
        else $error("result produced outside a get commit");

endmodule

`default_nettype wire

// ----- tb/lkvc_checker.sv -----
// ----------------------------------------------------------------------------
// lkvc_checker: read-result checker for the LRU key-value cache
// Watches the access, result and capacity ports, keeps its own copy of the
// cache contents and recency order, and compares every read result in turn.
// ----------------------------------------------------------------------------
module lkvc_checker
    import lkvc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  in_item_t           in_item,
    input  logic               out_valid,
    input  logic               out_stall,
    input  out_item_t          out_item,
    input  logic               cfg_write_en,
    input  logic [CAP_W-1:0]   cfg_write_data,
    output int                 mismatch_count,
    output int                 reads_pending,
    output int                 reads_checked,
    output int                 hits_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [DATA_W-1:0] line_key   [ENTRIES];
    logic [DATA_W-1:0] line_value [ENTRIES];
    bit                line_used  [ENTRIES];
    int                line_age   [ENTRIES];
    int                lines_held;
    logic [CAP_W-1:0]  capacity;
    out_item_t         expected_reads [$];

    function void clear_cache();
        for (int i = 0; i < ENTRIES; i++)
        begin
            line_used[i] = 1'b0;
            line_age[i]  = 0;
        end
        lines_held = 0;
        capacity   = CAP_RESET;
        expected_reads.delete();
        mismatch_count = 0;
        reads_checked  = 0;
        hits_checked   = 0;
    endfunction

    function int usable_lines();
        int lim;
        lim = int'(capacity);
        if (lim == 0)
            lim = 1;
        if (lim > ENTRIES)
            lim = ENTRIES;
        return lim;
    endfunction

    function int find_line(logic [DATA_W-1:0] key);
        for (int i = 0; i < ENTRIES; i++)
            if (line_used[i] && line_key[i] == key)
                return i;
        return -1;
    endfunction

    // Make line s the newest; age the lines that were newer than it.
    function void make_newest(int s);
        int old_age;
        old_age = line_age[s];
        for (int i = 0; i < ENTRIES; i++)
            if (line_used[i] && i != s && line_age[i] < old_age)
                line_age[i]++;
        line_age[s] = 0;
    endfunction

    function void apply_access(in_item_t it);
        int        s;
        int        free_line;
        int        victim;
        out_item_t rd;
        s = find_line(it.lookup_key);
        if (it.opcode == OP_GET)
        begin
            if (s >= 0)
            begin
                make_newest(s);
                rd.hit        = 1'b1;
                rd.read_value = line_value[s];
            end
            else
            begin
                rd.hit        = 1'b0;
                rd.read_value = '1;
            end
            expected_reads.push_back(rd);
            return;
        end
        if (s >= 0)
        begin
            line_value[s] = it.write_value;
            make_newest(s);
            return;
        end
        free_line = -1;
        if (lines_held < usable_lines())
            for (int i = 0; i < ENTRIES; i++)
                if (!line_used[i] && free_line < 0)
                    free_line = i;
        if (free_line >= 0)
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (line_used[i])
                    line_age[i]++;
            line_used[free_line]  = 1'b1;
            line_key[free_line]   = it.lookup_key;
            line_value[free_line] = it.write_value;
            line_age[free_line]   = 0;
            lines_held++;
            return;
        end
        // Full: replace the oldest line, the highest index on a tie.
        victim = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (line_used[i] && (victim < 0 || line_age[i] >= line_age[victim]))
                victim = i;
        if (victim >= 0)
        begin
            line_key[victim]   = it.lookup_key;
            line_value[victim] = it.write_value;
            make_newest(victim);
        end
    endfunction

    function void check_read(out_item_t got);
        out_item_t want;
        if (expected_reads.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: unexpected read result: expected none, got hit=%0b value=%0d",
                     $time, got.hit, got.read_value);
            return;
        end
        want = expected_reads.pop_front();
        reads_checked++;
        if (want.hit)
            hits_checked++;
        if (got.hit !== want.hit)
        begin
            mismatch_count++;
            $display("%0t: hit flag mismatch: expected %0b, got %0b",
                     $time, want.hit, got.hit);
        end
        if (got.read_value !== want.read_value)
        begin
            mismatch_count++;
            $display("%0t: read value mismatch: expected %0d, got %0d",
                     $time, want.read_value, got.read_value);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clear_cache();
        else
        begin
            if (out_valid && !out_stall)
                check_read(out_item);
            if (cfg_write_en)
                capacity = cfg_write_data;
            if (in_valid && !in_stall)
                apply_access(in_item);
        end
        reads_pending = expected_reads.size();
    end

endmodule

// ----- tb/tb_lru_key_value_cache_unit.sv -----
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_unit: testbench of the LRU key-value cache
// Drives directed and random get/put traffic over a range of capacities,
// with random idle and stall bursts; the checker predicts each read result.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import lkvc_pkg::*;

    localparam int PHASE_ITEMS = 150;
    // Cycles to let a put finish after the last read result has come back.
    localparam int SETTLE = ENTRIES + 8;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    in_item_t         in_item;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_item_t        out_item;
    logic             cfg_write_en;
    logic [CAP_W-1:0] cfg_write_data;

    int mismatch_count;
    int reads_pending;
    int reads_checked;
    int hits_checked;

    bit                calm;          // set for the closing phase: no idling at all
    int                gets_sent;
    int                puts_sent;
    int                settings_used;
    logic [DATA_W-1:0] key_pool [$];

    // Capacities of the random phases: zero, above the store, lowered
    // below the fill level, and ordinary sizes.
    int phase_caps [10] = '{0, 31, 5, 16, 8, 1, 17, 3, 12, 16};

    lru_key_value_cache_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_item       (out_item),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    lkvc_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_item       (out_item),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .mismatch_count (mismatch_count),
        .reads_pending  (reads_pending),
        .reads_checked  (reads_checked),
        .hits_checked   (hits_checked)
    );

    always #10 clk = ~clk;

    // Result side: alternate random stall bursts with free stretches; hold
    // stall low throughout the closing phase.
    int stall_left = 0;
    bit stalling   = 1'b0;

    always @(negedge clk)
    begin
        if (calm)
        begin
            out_stall  <= 1'b0;
            stall_left  = 0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stalling   = ($urandom_range(0, 2) == 0);
                stall_left = stalling ? $urandom_range(1, 15) : $urandom_range(1, 40);
            end
            out_stall <= stalling;
            stall_left--;
        end
    end

    // Present one item at the falling edge and hold it until the rising
    // edge that accepts it.
    task automatic access(logic op, logic [DATA_W-1:0] key, logic [DATA_W-1:0] val);
        in_item_t it;
        it.opcode      = op;
        it.lookup_key  = key;
        it.write_value = val;
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == OP_GET)
            gets_sent++;
        else
            puts_sent++;
    endtask

    // Drop valid for a random burst, now and then.
    task automatic maybe_idle();
        int n;
        if (calm || $urandom_range(0, 3) != 0)
            return;
        n = $urandom_range(1, 15);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1)
            @(negedge clk);
    endtask

    // Stop sending, wait for every read result, then let a trailing put
    // finish its scan and commit.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (reads_pending != 0)
            @(negedge clk);
        repeat (SETTLE)
            @(negedge clk);
    endtask

    // Write the capacity only once the cache has gone quiet.
    task automatic set_capacity(int cap);
        drain();
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= CAP_W'(cap);
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        int cap_eff;
        int pool_size;
        logic              op;
        logic [DATA_W-1:0] key;

        in_valid       = 1'b0;
        in_item        = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        rst_n          = 1'b0;
        gets_sent      = 0;
        puts_sent      = 0;
        settings_used  = 1;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset capacity: a read of the empty cache,
        // extreme keys and values, reads of each, an overwrite, a plain miss.
        access(OP_GET, 32'h1234_5678, 32'h0);
        access(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        access(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        access(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        access(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        access(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        access(OP_GET, 32'h7FFF_FFFF, 32'h0);
        access(OP_GET, 32'hFFFF_FFFF, 32'h0);
        access(OP_GET, 32'h0000_0000, 32'h0);
        access(OP_PUT, 32'h7FFF_FFFF, 32'h5A5A_A5A5);
        access(OP_GET, 32'h7FFF_FFFF, 32'h0);
        access(OP_GET, 32'h0000_0001, 32'h0);

        // Lower the capacity below the fill level: a new key must replace
        // the oldest line without the count dropping.
        set_capacity(1);
        access(OP_PUT, 32'hDEAD_BEEF, 32'h0000_0001);
        access(OP_GET, 32'hDEAD_BEEF, 32'h0);
        access(OP_GET, 32'h8000_0000, 32'h0);
        access(OP_GET, 32'h0000_0000, 32'h0);
        access(OP_PUT, 32'hCAFE_F00D, 32'h0000_0002);
        access(OP_GET, 32'hDEAD_BEEF, 32'h0);

        // Random phases: keys mostly from a pool a little larger than the
        // capacity so that hits, misses, overwrites and replacements all
        // happen; a tenth of the keys are fresh noise.
        for (int p = 0; p < $size(phase_caps); p++)
        begin
            set_capacity(phase_caps[p]);
            if (p == $size(phase_caps) - 1)
                calm = 1'b1;
            cap_eff = phase_caps[p];
            if (cap_eff < 1)
                cap_eff = 1;
            if (cap_eff > ENTRIES)
                cap_eff = ENTRIES;
            pool_size = cap_eff + $urandom_range(1, 6);
            key_pool.delete();
            repeat (pool_size)
                key_pool.push_back($urandom);
            repeat (PHASE_ITEMS)
            begin
                maybe_idle();
                op = $urandom_range(0, 1) ? OP_PUT : OP_GET;
                if ($urandom_range(0, 9) == 0)
                    key = $urandom;
                else
                    key = key_pool[$urandom_range(0, pool_size - 1)];
                access(op, key, $urandom);
            end
        end

        drain();
        $display("Run covered %0d accesses (%0d gets, %0d puts) over %0d capacity settings.",
                 gets_sent + puts_sent, gets_sent, puts_sent, settings_used);
        $display("Read results checked: %0d, of which %0d hits.", reads_checked, hits_checked);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Guard against a hung handshake: far beyond the slowest correct run.
    initial
    begin
        #10ms;
        $display("Timeout: the run did not complete.");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
